/* src/bpt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bpt_pkg
// Shared widths, register indexes, calibration and stage control types for the
// barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bpt_pkg;

    localparam int RAW_W    = 24;
    localparam int TEMP_W   = 24;
    localparam int PRESS_W  = 23;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W    = 128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PSENS_CAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POFF_CAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PQUAD_CAL = 2'd3;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7FFFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -24'sh800000;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 23'h7FFFFF;

    // Unpacked calibration coefficients.
    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } cal_t;

    // Handshake controls of one pipeline stage.
    typedef struct packed {
        logic adv;
        logic flush_sat;
    } stg_ctl_t;

endpackage : bpt_pkg
`default_nettype wire

/* src/baro_pressure_temp_compensation.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Compensates raw pressure and temperature readings with the
// 14-coefficient calibration polynomial.
// ---------------------------------------------------------------------------
// Use: s_axis_tdata carries one pair of raw readings per transfer; the
// result leaves on m_axis_tdata. Calibration is written through cfg_we,
// cfg_addr and cfg_wdata while the pipeline is empty.
// Structure: ten register stages, four for temperature and six for pressure,
// the last one holding the final sum. Throughput: one transfer per cycle
// while m_axis_tready allows; the whole pipeline advances together.
// A stall on m_axis_tready freezes every stage and drops s_axis_tready, so
// nothing is lost or repeated. Reset clears all valid bits and the
// calibration registers.
// ---------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // temperature [23:0], pressure [46:24], saturated [47]
    output logic [47:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [bpt_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [bpt_pkg::CFG_W-1:0]     cfg_wdata
);
    localparam int DEPTH = 10;

    logic [39:0] tcal_reg;
    logic [47:0] pscal_reg, pocal_reg;
    logic [31:0] pqcal_reg;
    bpt_pkg::cal_t cal;
    logic [DEPTH-1:0] vld_reg;
    logic en;
    logic signed [bpt_pkg::TEMP_W-1:0] tq;
    logic tsat;
    logic [bpt_pkg::PRESS_W-1:0] pq;
    logic psat;
    logic signed [bpt_pkg::TEMP_W-1:0] tdl_reg [6];
    logic [5:0] sdl_reg;
    logic [bpt_pkg::RAW_W-1:0] up_reg [4];

    // Whole pipeline moves when the output slot is free or being taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_comb begin
        cal = '{t1: tcal_reg[15:0], t2: tcal_reg[31:16], t3: tcal_reg[39:32],
                p1: pscal_reg[15:0], p2: pscal_reg[31:16], p3: pscal_reg[39:32],
                p4: pscal_reg[47:40], p5: pocal_reg[15:0], p6: pocal_reg[31:16],
                p7: pocal_reg[39:32], p8: pocal_reg[47:40], p9: pqcal_reg[15:0],
                p10: pqcal_reg[23:16], p11: pqcal_reg[31:24]};
    end

    // Calibration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0; pscal_reg <= '0; pocal_reg <= '0; pqcal_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                bpt_pkg::REG_TEMP_CAL:  tcal_reg  <= cfg_wdata[39:0];
                bpt_pkg::REG_PSENS_CAL: pscal_reg <= cfg_wdata;
                bpt_pkg::REG_POFF_CAL:  pocal_reg <= cfg_wdata;
                bpt_pkg::REG_PQUAD_CAL: pqcal_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    bpt_temp u_temp (.aclk(aclk), .en(en), .ut(s_axis_tdata[47:24]), .cal(cal),
                     .tq(tq), .tsat(tsat));

    // Raw pressure waits while temperature is worked out; temperature then
    // waits while pressure is worked out.
    always_ff @(posedge aclk) begin
        if (en) begin
            up_reg[0] <= s_axis_tdata[23:0];
            up_reg[1] <= up_reg[0];
            up_reg[2] <= up_reg[1];
            up_reg[3] <= up_reg[2];
            tdl_reg[0] <= tq; sdl_reg[0] <= tsat;
            for (int i = 1; i < 6; i++) begin
                tdl_reg[i] <= tdl_reg[i-1]; sdl_reg[i] <= sdl_reg[i-1];
            end
        end
    end

    bpt_press u_press (.aclk(aclk), .en(en), .up(up_reg[3]), .s(tq), .cal(cal),
                       .pq(pq), .psat(psat));

    assign m_axis_tdata = {sdl_reg[5] | psat, pq, tdl_reg[5]};

    // Output must not change while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // Input is taken exactly when the pipeline advances.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready disagrees with advance");
    // A clamped temperature always flags saturation on output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && sdl_reg[5] |-> m_axis_tdata[47])
        else $error("saturation flag lost");
endmodule : baro_pressure_temp_compensation
`default_nettype wire

/* src/bpt_temp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bpt_temp
// Temperature quadratic in four stages: offset, offset times each
// coefficient, the two terms, then sum with floor and clamp.
// ---------------------------------------------------------------------------
module bpt_temp (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [bpt_pkg::RAW_W-1:0]         ut,
    input  wire bpt_pkg::cal_t                     cal,
    output logic signed [bpt_pkg::TEMP_W-1:0]      tq,
    output logic                                   tsat
);
    localparam logic signed [30:0] TEMP_MAX_EXT = 31'sd8388607;
    localparam logic signed [30:0] TEMP_MIN_EXT = -31'sd8388608;

    // Stage 1: offset from the reference point.
    logic signed [25:0] d_reg, d_next;
    // Stage 2: offset times t2 and times t3.
    logic signed [42:0] dt2_reg, dt2_next;
    logic signed [33:0] dt3_reg, dt3_next;
    logic signed [25:0] d2_reg, d2_next;
    // Stage 3: both terms.
    logic signed [61:0] lin_reg, lin_next;
    logic signed [61:0] quad_reg, quad_next;
    // Stage 4: floored and clamped temperature.
    logic signed [bpt_pkg::TEMP_W-1:0] tq_reg, tq_next;
    logic tsat_reg, tsat_next;
    logic signed [62:0] n_sum;
    logic signed [30:0] n_fl;

    always_comb begin
        d_next    = $signed({2'b00, ut}) - $signed({2'b00, cal.t1, 8'h00});
        dt2_next  = 43'(d_reg * $signed({1'b0, cal.t2}));
        dt3_next  = 34'(d_reg * cal.t3);
        d2_next   = d_reg;
        lin_next  = 62'(dt2_reg) <<< 18;
        quad_next = 62'(dt3_reg * d2_reg);
        n_sum     = 63'(lin_reg) + 63'(quad_reg);
        // Arithmetic shift floors toward minus infinity.
        n_fl      = 31'(n_sum >>> 32);
        if (n_fl > TEMP_MAX_EXT) begin
            tq_next = bpt_pkg::TEMP_MAX; tsat_next = 1'b1;
        end else if (n_fl < TEMP_MIN_EXT) begin
            tq_next = bpt_pkg::TEMP_MIN; tsat_next = 1'b1;
        end else begin
            tq_next = n_fl[23:0]; tsat_next = 1'b0;
        end
    end

    assign tq   = tq_reg;
    assign tsat = tsat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            dt2_reg  <= dt2_next;
            dt3_reg  <= dt3_next;
            d2_reg   <= d2_next;
            lin_reg  <= lin_next;
            quad_reg <= quad_next;
            tq_reg   <= tq_next;
            tsat_reg <= tsat_next;
        end
    end
endmodule : bpt_temp
`default_nettype wire

/* src/bpt_press.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bpt_press
// Pressure cubic in six stages. The polynomial is regrouped by powers of
// the temperature and evaluated by Horner's rule; wide operands are split
// into limbs so each multiplier stays narrow.
// ---------------------------------------------------------------------------
module bpt_press (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [bpt_pkg::RAW_W-1:0]         up,
    input  wire logic signed [bpt_pkg::TEMP_W-1:0] s,
    input  wire bpt_pkg::cal_t                     cal,
    output logic [bpt_pkg::PRESS_W-1:0]            pq,
    output logic                                   psat
);
    localparam int AW = bpt_pkg::ACC_W;

    logic signed [24:0] up_s;
    logic signed [16:0] p1m, p2m;

    // Stage 1: coefficient groups that are linear in the raw pressure.
    logic signed [33:0] c3_reg, c3_next;
    logic signed [33:0] c2_reg, c2_next;
    logic signed [36:0] r_reg, r_next;
    logic signed [33:0] q_reg, q_next;
    logic signed [23:0] sp1_reg;
    logic signed [24:0] upp1_reg;
    // Stage 2: inner Horner step and the second pressure factor.
    logic signed [57:0] h2_reg, h2_next;
    logic signed [61:0] c1_reg, c1_next;
    logic signed [62:0] w_reg, w_next;
    logic signed [23:0] sp2_reg;
    logic signed [24:0] upp2_reg;
    // Stage 3: limb products.
    logic signed [52:0] mh_reg, mh_next;
    logic signed [53:0] ml_reg, ml_next;
    logic signed [55:0] wh_reg, wh_next;
    logic signed [57:0] wl_reg, wl_next;
    logic signed [61:0] c1d_reg;
    logic signed [23:0] sp3_reg;
    // Stage 4: middle Horner step and the constant group.
    logic signed [83:0] h1_reg, h1_next;
    logic signed [AW-1:0] c0_reg, c0_next;
    logic signed [23:0] sp4_reg;
    // Stage 5: limb products of the outer step.
    logic signed [52:0] g0_reg, g0_next;
    logic signed [52:0] g1_reg, g1_next;
    logic signed [51:0] g2_reg, g2_next;
    logic signed [AW-1:0] c0d_reg;
    // Stage 6: total in units of 2^-79 of the output step.
    logic signed [AW-1:0] acc_reg, acc_next;

    always_comb begin
        up_s = $signed({1'b0, up});
        p1m  = 17'(cal.p1) - 17'sd16384;
        p2m  = 17'(cal.p2) - 17'sd16384;
        // Coefficients of s^3, s^2 and the inner parts of the s and constant groups.
        c3_next = 34'(up_s * cal.p4) + (34'(cal.p8) <<< 22);
        c2_next = 34'(up_s * cal.p3) + (34'(cal.p7) <<< 24);
        r_next  = 37'(up_s * cal.p10) + (37'(p2m) <<< 19);
        q_next  = 34'(up_s * cal.p11) + (34'(cal.p9) <<< 17);
        h2_next = 58'(c3_reg * sp1_reg) + (58'(c2_reg) <<< 21);
        c1_next = 62'(r_reg * upp1_reg) + (62'($signed({1'b0, cal.p6})) <<< 42);
        w_next  = 63'(q_reg * upp1_reg) + (63'(p1m) <<< 45);
        // Split products: high limb signed, low limb zero-extended.
        mh_next = 53'($signed(h2_reg[57:29]) * sp2_reg);
        ml_next = 54'($signed({1'b0, h2_reg[28:0]}) * sp2_reg);
        wh_next = 56'($signed(w_reg[62:32]) * upp2_reg);
        wl_next = 58'($signed({1'b0, w_reg[31:0]}) * upp2_reg);
        h1_next = (84'(mh_reg) <<< 29) + 84'(ml_reg) + (84'(c1d_reg) <<< 21);
        c0_next = (AW'(wh_reg) <<< 52) + (AW'(wl_reg) <<< 20)
                + (AW'($signed({1'b0, cal.p5})) <<< 88);
        g0_next = 53'($signed({1'b0, h1_reg[27:0]}) * sp4_reg);
        g1_next = 53'($signed({1'b0, h1_reg[55:28]}) * sp4_reg);
        g2_next = 52'($signed(h1_reg[83:56]) * sp4_reg);
        acc_next = (AW'(g2_reg) <<< 56) + (AW'(g1_reg) <<< 28) + AW'(g0_reg) + c0d_reg;
        // Floor to 1/64 Pa and clamp to the output range.
        if (acc_reg[AW-1]) begin
            pq = '0; psat = 1'b1;
        end else if (acc_reg[AW-2:79+bpt_pkg::PRESS_W] != '0) begin
            pq = bpt_pkg::PRESS_MAX; psat = 1'b1;
        end else begin
            pq = acc_reg[79 +: bpt_pkg::PRESS_W]; psat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg   <= c3_next;
            c2_reg   <= c2_next;
            r_reg    <= r_next;
            q_reg    <= q_next;
            sp1_reg  <= s;
            upp1_reg <= up_s;
            h2_reg   <= h2_next;
            c1_reg   <= c1_next;
            w_reg    <= w_next;
            sp2_reg  <= sp1_reg;
            upp2_reg <= upp1_reg;
            mh_reg   <= mh_next;
            ml_reg   <= ml_next;
            wh_reg   <= wh_next;
            wl_reg   <= wl_next;
            c1d_reg  <= c1_reg;
            sp3_reg  <= sp2_reg;
            h1_reg   <= h1_next;
            c0_reg   <= c0_next;
            sp4_reg  <= sp3_reg;
            g0_reg   <= g0_next;
            g1_reg   <= g1_next;
            g2_reg   <= g2_next;
            c0d_reg  <= c0_reg;
            acc_reg  <= acc_next;
        end
    end
endmodule : bpt_press
`default_nettype wire

/* tb/tb_baro_pressure_temp_compensation.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation
// Self-checking bench for the barometric compensation pipeline. Raw
// pressure and temperature pairs are streamed in under several calibration
// sets: all zero, all ones, a typical sensor and random ones. Every result
// is compared field by field with a predictor that evaluates the
// compensation polynomial exactly in wide integers. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------

// Scoreboard: keeps its own calibration copy and the queue of predicted results.
class compensation_scoreboard;

    typedef logic signed [127:0] wide_t;

    logic [39:0] temp_cal;
    logic [47:0] sens_cal;
    logic [47:0] offs_cal;
    logic [31:0] quad_cal;
    logic [47:0] predicted_q[$];
    int          errors;
    int          matched;
    int          sat_seen;

    function new();
        temp_cal = '0;
        sens_cal = '0;
        offs_cal = '0;
        quad_cal = '0;
        errors   = 0;
        matched  = 0;
        sat_seen = 0;
    endfunction

    // Mirrors one register write, masked to the register width.
    function void write_cal(logic [bpt_pkg::CFG_IDX_W-1:0] idx, logic [47:0] v);
        case (idx)
            bpt_pkg::REG_TEMP_CAL:  temp_cal = v[39:0];
            bpt_pkg::REG_PSENS_CAL: sens_cal = v;
            bpt_pkg::REG_POFF_CAL:  offs_cal = v;
            bpt_pkg::REG_PQUAD_CAL: quad_cal = v[31:0];
            default: ;
        endcase
    endfunction

    // Works out the packed result for one raw reading pair.
    function logic [47:0] compensate(logic [23:0] raw_p, logic [23:0] raw_t);
        longint d, n, tq;
        wide_t  up, s, s2, u2, acc;
        wide_t  t1, t2, t3;
        wide_t  p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic [127:0] pq;
        logic   sat;
        sat = 1'b0;
        t1  = wide_t'(temp_cal[15:0]);
        t2  = wide_t'(temp_cal[31:16]);
        t3  = wide_t'(signed'(temp_cal[39:32]));
        p1  = wide_t'(signed'(sens_cal[15:0]));
        p2  = wide_t'(signed'(sens_cal[31:16]));
        p3  = wide_t'(signed'(sens_cal[39:32]));
        p4  = wide_t'(signed'(sens_cal[47:40]));
        p5  = wide_t'(offs_cal[15:0]);
        p6  = wide_t'(offs_cal[31:16]);
        p7  = wide_t'(signed'(offs_cal[39:32]));
        p8  = wide_t'(signed'(offs_cal[47:40]));
        p9  = wide_t'(signed'(quad_cal[15:0]));
        p10 = wide_t'(signed'(quad_cal[23:16]));
        p11 = wide_t'(signed'(quad_cal[31:24]));

        // Temperature quadratic, floored to 1/65536 degC.
        d  = longint'(raw_t) - longint'(t1) * 256;
        n  = d * longint'(t2) * 262144 + d * d * longint'(t3);
        tq = n >>> 32;
        if (tq > 64'sd8388607) begin
            tq  = 64'sd8388607;
            sat = 1'b1;
        end
        if (tq < -64'sd8388608) begin
            tq  = -64'sd8388608;
            sat = 1'b1;
        end

        // Pressure cubic over a common scale of 2^79 output units.
        s   = wide_t'(tq);
        s2  = s * s;
        up  = wide_t'(raw_p);
        u2  = up * up;
        acc = (p5 <<< 88) + ((p6 * s) <<< 63) + ((p7 * s2) <<< 45)
            + ((p8 * s2 * s) <<< 22) + ((up * (p1 - 16384)) <<< 65)
            + ((up * (p2 - 16384) * s) <<< 40) + ((up * p3 * s2) <<< 21)
            + (up * p4 * s2 * s) + ((u2 * p9) <<< 37)
            + ((u2 * p10 * s) <<< 21) + ((u2 * up * p11) <<< 20);
        if (acc < 0) begin
            pq  = '0;
            sat = 1'b1;
        end else begin
            pq = acc >>> 79;
            if (pq > 128'(bpt_pkg::PRESS_MAX)) begin
                pq  = 128'(bpt_pkg::PRESS_MAX);
                sat = 1'b1;
            end
        end
        return {sat, pq[22:0], tq[23:0]};
    endfunction

    function void note_sample(logic [47:0] tdata);
        predicted_q.push_back(compensate(tdata[23:0], tdata[47:24]));
    endfunction

    function void check_result(logic [47:0] got);
        logic [47:0] want;
        if (predicted_q.size() == 0) begin
            $display("%0t: result with nothing expected: %h", $time, got);
            errors++;
            return;
        end
        want = predicted_q.pop_front();
        if (want[23:0] !== got[23:0]) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(want[23:0]), $signed(got[23:0]));
            errors++;
        end
        if (want[46:24] !== got[46:24]) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     want[46:24], got[46:24]);
            errors++;
        end
        if (want[47] !== got[47]) begin
            $display("%0t: saturated expected %b actual %b", $time, want[47], got[47]);
            errors++;
        end
        matched++;
        if (want[47]) sat_seen++;
    endfunction

    function int pending();
        return predicted_q.size();
    endfunction

endclass

module tb_baro_pressure_temp_compensation;

    import bpt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // raw_pressure [23:0], raw_temperature [47:24]
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // temperature [23:0], pressure [46:24], saturated [47]
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    compensation_scoreboard board;
    int  hold_off_cycles;
    bit  no_idle;
    int  sample_count;
    int  cal_sets;

    baro_pressure_temp_compensation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("tb_baro_pressure_temp_compensation: done, errors");
        $finish;
    end

    // Result side: check each transfer, then decide the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready   <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 6);
            end
        end
    end

    // Offers one reading pair and waits for its transfer.
    task automatic send_sample(logic [23:0] raw_p, logic [23:0] raw_t);
        if (!no_idle && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_t, raw_p};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_sample({raw_t, raw_p});
        sample_count++;
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() > 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Writes all four calibration registers, pipeline idle.
    task automatic load_calibration(logic [39:0] tc, logic [47:0] sc,
                                    logic [47:0] oc, logic [31:0] qc);
        logic [47:0] vals [4];
        vals[0] = {8'h00, tc};
        vals[1] = sc;
        vals[2] = oc;
        vals[3] = {16'h0000, qc};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            board.write_cal(CFG_IDX_W'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        cal_sets++;
    endtask

    // A plausible sensor: t1 near 27000, small cubic terms.
    task automatic load_typical();
        logic [15:0] t1;
        t1 = 16'($urandom_range(26000, 28000));
        load_calibration({8'hF9, 16'($urandom_range(18000, 20000)), t1},
                         {8'h00, 8'hFD, 16'h1000, 16'hF800},
                         {8'hF6, 8'h03, 16'h5DC0, 16'h4E20},
                         {8'hC4, 8'h0A, 16'h3A98});
    endtask

    // Random items: mostly temperatures near the calibrated origin.
    task automatic random_burst(int count);
        logic [23:0] raw_t;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 7)
                raw_t = 24'({board.temp_cal[15:0], 8'h00} + $urandom_range(0, 2000000)
                        - 1000000);
            else
                raw_t = 24'($urandom);
            send_sample(24'($urandom), raw_t);
        end
    endtask

    initial begin
        board           = new();
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        hold_off_cycles = 0;
        no_idle         = 1'b0;
        sample_count    = 0;
        cal_sets        = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unset calibration: the polynomial runs on zeros.
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h800000, 24'h7FFFFF);
        drain();

        // Typical sensor: field extremes, both clamps of each value.
        load_typical();
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'hFFFFFF, 24'h000000);
        send_sample(24'h000000, 24'hFFFFFF);
        send_sample(24'h555555, 24'hAAAAAA);
        send_sample(24'hAAAAAA, 24'h555555);
        send_sample(24'h700000, {board.temp_cal[15:0], 8'h00});
        send_sample(24'h600000, 24'h6C0000);
        send_sample(24'h000001, 24'h6A0000);
        drain();

        // All-ones calibration: widest coefficients.
        load_calibration('1, '1, '1, '1);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h123456, 24'hFFFF00);
        send_sample(24'hFEDCBA, 24'h000100);
        drain();

        // Random content under typical and random calibration sets.
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0)
                load_typical();
            else
                load_calibration({8'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                                 {16'($urandom), 32'($urandom)}, 32'($urandom));
            no_idle = (phase == 2);
            if (phase == 4) hold_off_cycles = 80;
            random_burst(52);
            drain();
        end
        no_idle = 1'b0;

        if (board.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending());
            board.errors++;
        end
        $display("Sent %0d samples under %0d calibration sets; %0d results checked,",
                 sample_count, cal_sets, board.matched);
        $display("%0d of them clamped, with idling, back-pressure and a long stall.",
                 board.sat_seen);
        if (board.errors == 0)
            $display("tb_baro_pressure_temp_compensation: done, clean");
        else
            $display("tb_baro_pressure_temp_compensation: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
